// ----- hw/rtl/eife_pkg.sv -----
// Package for the EXI integer field encoder: item, chunk and command types,
// function codes and queue sizing. No dependencies.
package eife_pkg;

  localparam logic [1:0] FUNC_NBIT     = 2'd0;
  localparam logic [1:0] FUNC_BOOL     = 2'd1;
  localparam logic [1:0] FUNC_UINT     = 2'd2;
  localparam logic [1:0] FUNC_SINT     = 2'd3;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] value;
    logic [5:0]  bit_count;
  } item_t;

  typedef struct packed {
    logic [31:0] chunk_bits;
    logic [5:0]  chunk_width;
    logic        last;
  } chunk_t;

  typedef enum logic [2:0] {
    KIND_SINGLE = 3'b001,
    KIND_BYTES  = 3'b010,
    KIND_VARINT = 3'b100
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic        sign_pre;
    logic        sign_bit;
    logic [31:0] data;
    logic [5:0]  width;
    logic [2:0]  count;
  } cmd_t;

endpackage

// ----- hw/rtl/eife_front.sv -----
// Front end: classifies one item into an encoding command.
// Depends on eife_pkg.
module eife_front #(
  parameter int VALUE_WIDTH = 32
) (
  input  eife_pkg::item_t item,
  input  logic            bit_packed_mode,
  output eife_pkg::cmd_t  cmd
);

  localparam int EFF_W = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam logic [31:0] W_MASK = 32'((64'd1 << EFF_W) - 64'd1);
  localparam logic [5:0]  W_LIM  = 6'(EFF_W);

  logic [31:0] v;
  logic [5:0]  n_sat;
  logic [31:0] vn;
  logic [6:0]  n_plus;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] vin;
  logic [2:0]  groups;

  always_comb begin
    v      = item.value & W_MASK;
    n_sat  = (item.bit_count > W_LIM) ? W_LIM : item.bit_count;
    vn     = v & ~({32{1'b1}} << n_sat);
    n_plus = {1'b0, n_sat} + 7'd7;
    neg    = v[EFF_W-1];
    mag    = neg ? (~v & W_MASK) : v;
    vin    = (item.func == eife_pkg::FUNC_SINT) ? mag : v;
    if (vin[31:28] != '0) begin
      groups = 3'd5;
    end else if (vin[27:21] != '0) begin
      groups = 3'd4;
    end else if (vin[20:14] != '0) begin
      groups = 3'd3;
    end else if (vin[13:7] != '0) begin
      groups = 3'd2;
    end else begin
      groups = 3'd1;
    end
  end

  always_comb begin
    cmd          = '0;
    cmd.kind     = eife_pkg::KIND_SINGLE;
    cmd.count    = 3'd1;
    unique case (item.func)
      eife_pkg::FUNC_NBIT: begin
        cmd.data = vn;
        if (n_sat == '0 || bit_packed_mode) begin
          cmd.width = n_sat;
        end else begin
          cmd.kind  = eife_pkg::KIND_BYTES;
          cmd.count = n_plus[5:3];
        end
      end
      eife_pkg::FUNC_BOOL: begin
        cmd.data  = {31'd0, v[0]};
        cmd.width = 6'd1;
      end
      eife_pkg::FUNC_UINT, eife_pkg::FUNC_SINT: begin
        cmd.kind     = eife_pkg::KIND_VARINT;
        cmd.data     = vin;
        cmd.count    = groups;
        cmd.sign_pre = (item.func == eife_pkg::FUNC_SINT);
        cmd.sign_bit = neg;
      end
      default: begin
        cmd.data = '0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/eife_queue.sv -----
// Short command queue between front and back ends.
// Depends on eife_pkg.
module eife_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  eife_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd,
  output eife_pkg::cmd_t rd_cmd,
  output logic           empty
);

  localparam int D  = eife_pkg::QUEUE_DEPTH;
  localparam int PW = (D > 1) ? $clog2(D) : 1;
  localparam int CW = $clog2(D + 1);

  eife_pkg::cmd_t   mem [D];
  logic [PW-1:0]    wp;
  logic [PW-1:0]    rp;
  logic [CW-1:0]    cnt;

  assign full   = (cnt == CW'(D));
  assign empty  = (cnt == '0);
  assign rd_cmd = mem[rp];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      mem[wp] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (wr && !full) begin
        wp <= (wp == PW'(D - 1)) ? '0 : PW'(wp + 1'b1);
      end
      if (rd && !empty) begin
        rp <= (rp == PW'(D - 1)) ? '0 : PW'(rp + 1'b1);
      end
      cnt <= CW'(cnt + CW'(wr && !full) - CW'(rd && !empty));
    end
  end

endmodule

// ----- hw/rtl/eife_back.sv -----
// Back end: steps through a command one chunk per cycle into the output register, while it is empty or popped.
// Depends on eife_pkg.
module eife_back (
  input  logic            clk,
  input  logic            rst,
  input  eife_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output eife_pkg::chunk_t chunk,
  output logic            empty,
  input  logic            pop
);

  logic             out_valid;
  logic [2:0]       idx;
  logic             sign_done;
  logic             step;
  logic             sign_phase;
  logic [5:0]       sh_amt;
  logic [31:0]      sh;
  logic             more;
  eife_pkg::chunk_t nxt;

  assign step       = !cmd_empty && (!out_valid || pop);
  assign sign_phase = cmd.sign_pre && !sign_done;
  assign empty      = !out_valid;
  assign cmd_pop    = step && nxt.last;

  always_comb begin
    sh_amt = (cmd.kind == eife_pkg::KIND_BYTES) ? {idx, 3'b000}
                                                : 6'({idx, 3'b000} - {3'b000, idx});
    sh     = cmd.data >> sh_amt;
    more   = (3'(idx + 3'd1) != cmd.count);
    nxt    = '0;
    if (sign_phase) begin
      nxt.chunk_bits  = {31'd0, cmd.sign_bit};
      nxt.chunk_width = 6'd1;
      nxt.last        = 1'b0;
    end else begin
      unique case (cmd.kind)
        eife_pkg::KIND_SINGLE: begin
          nxt.chunk_bits  = cmd.data;
          nxt.chunk_width = cmd.width;
          nxt.last        = 1'b1;
        end
        eife_pkg::KIND_BYTES: begin
          nxt.chunk_bits  = {24'd0, sh[7:0]};
          nxt.chunk_width = 6'd8;
          nxt.last        = !more;
        end
        eife_pkg::KIND_VARINT: begin
          nxt.chunk_bits  = {24'd0, more, sh[6:0]};
          nxt.chunk_width = 6'd8;
          nxt.last        = !more;
        end
        default: begin
          nxt.last = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      chunk <= nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
      sign_done <= 1'b0;
    end else begin
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (step) begin
        if (nxt.last) begin
          idx       <= '0;
          sign_done <= 1'b0;
        end else if (sign_phase) begin
          sign_done <= 1'b1;
        end else begin
          idx <= 3'(idx + 3'd1);
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_upper_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((chunk.chunk_bits >> chunk.chunk_width) == '0))
    else $error("chunk has bits above its width");
  a_inner_width: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !chunk.last) |-> (chunk.chunk_width == 6'd8 || chunk.chunk_width == 6'd1))
    else $error("inner chunk has odd width");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    !cmd_empty |-> (idx < cmd.count))
    else $error("chunk index past command count");
  a_sign_first: assert property (@(posedge clk) disable iff (rst)
    (step && sign_phase) |=> (out_valid && !chunk.last && chunk.chunk_width == 6'd1))
    else $error("sign chunk malformed");
`endif

endmodule

// ----- hw/rtl/exi_integer_field_encoder_core.sv -----
// EXI integer field encoder top level: config register, front end, queue, back end.
// Depends on eife_pkg, eife_front, eife_queue, eife_back.
//
// Encodes one value per item (n-bit unsigned, boolean, unsigned or signed
// integer) into EXI bit chunks, one chunk per result word. The back end emits
// one chunk per clock while its output register is empty or being popped. An
// item yields one chunk for boolean, n-bit bit-packed and zero-width fields,
// up to four for byte-aligned n-bit fields, up to five for unsigned and six for
// signed integers. A two-entry command queue lets new items be taken while
// earlier ones are still being emitted. bit_packed_mode resets to 1 and is
// written through the cfg channel, which is always ready.
module exi_integer_field_encoder_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  eife_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output eife_pkg::chunk_t  chunk,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_data
);

  logic           bit_packed_mode;
  eife_pkg::cmd_t front_cmd;
  eife_pkg::cmd_t head_cmd;
  logic           q_empty;
  logic           q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_packed_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      bit_packed_mode <= cfg_data;
    end
  end

  eife_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .item           (item),
    .bit_packed_mode(bit_packed_mode),
    .cmd            (front_cmd)
  );

  eife_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (push),
    .wr_cmd(front_cmd),
    .full  (full),
    .rd    (q_pop),
    .rd_cmd(head_cmd),
    .empty (q_empty)
  );

  eife_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd      (head_cmd),
    .cmd_empty(q_empty),
    .cmd_pop  (q_pop),
    .chunk    (chunk),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
